### src/scc_pkg.sv
package scc_pkg;

  localparam logic [7:0]  CRC_POLY      = 8'h8C;
  localparam int          CFG_ADDR_W    = 3;
  localparam logic        REG_THRESHOLD = 1'b0;   // register index, taken from paddr[2]
  localparam int          THRESH_W      = 11;
  localparam logic [10:0] THRESH_RESET  = 11'd50;
  localparam int          TENTHS_W      = 12;

  // one finished frame, handed from the byte front end to the result stage
  typedef struct packed {
    logic signed [TENTHS_W-1:0] tenths;
    logic                       ok;
  } reading_t;

endpackage

### src/scc_if.sv
interface scc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface scc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [scc_pkg::TENTHS_W-1:0]  temperature_tenths;
  logic                                 crc_ok;
  logic                                 big_change;

  modport source (output valid, output temperature_tenths, output crc_ok,
                  output big_change, input ready);
  modport sink   (input valid, input temperature_tenths, input crc_ok,
                  input big_change, output ready);
endinterface

### src/scc_front.sv
module scc_front #(
  parameter int FRAME_BYTES = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              frame_start,
  output logic              push,
  output scc_pkg::reading_t push_data
);

  logic [3:0]  count_r, count_nxt, count_eff, count_inc;
  logic [7:0]  crc_r, crc_nxt, crc_in, crc_new;
  logic [7:0]  low_r, high_r;
  logic        frame_end;
  logic signed [15:0] raw_ext, scaled;

  // reflected CRC-8, one bit per step, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_i, input logic [7:0] d);
    logic [7:0] c;
    logic       mix;
    c = crc_i;
    for (int b = 0; b < 8; b++) begin
      mix = c[0] ^ d[b];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ scc_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  always_comb begin
    count_eff = frame_start ? 4'd0 : count_r;
    crc_in    = frame_start ? 8'd0 : crc_r;
    crc_new   = crc8_byte(crc_in, data_byte);
    count_inc = count_eff + 4'd1;
    frame_end = accept && (count_inc == 4'(FRAME_BYTES));
    count_nxt = count_r;
    crc_nxt   = crc_r;
    if (accept) begin
      count_nxt = frame_end ? 4'd0 : count_inc;
      crc_nxt   = frame_end ? 8'd0 : crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd0;
      crc_r   <= 8'd0;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // temperature bytes, no reset needed
  always_ff @(posedge clk) begin
    if (accept && count_eff == 4'd0) begin
      low_r <= data_byte;
    end
    if (accept && count_eff == 4'd1) begin
      high_r <= data_byte;
    end
  end

  // raw*10/16 with floor: x*8 + x*2, then arithmetic shift by 4
  always_comb begin
    raw_ext = 16'(signed'({high_r[3:0], low_r}));
    scaled  = (raw_ext <<< 3) + (raw_ext <<< 1);
  end

  assign push             = frame_end;
  assign push_data.tenths = scaled[15:4];
  assign push_data.ok     = (crc_new == 8'd0);

endmodule

### src/scc_fifo.sv
module scc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  scc_pkg::reading_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output scc_pkg::reading_t head
);

  scc_pkg::reading_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && full |-> pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("queue fill out of range");

endmodule

### src/scc_back.sv
module scc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [scc_pkg::THRESH_W-1:0]  threshold,
  input  logic                          q_valid,
  input  scc_pkg::reading_t             q_head,
  output logic                          pop,
  scc_out_if.source                     out_ch
);

  logic signed [scc_pkg::TENTHS_W-1:0] last_good_r, last_good_nxt;
  logic signed [scc_pkg::TENTHS_W-1:0] tenths_r, tenths_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic        valid_r, valid_nxt;
  logic        ok_r, ok_nxt, big_r, big_nxt;
  logic signed [12:0] diff;
  logic [11:0] mag;

  assign pop = q_valid && (!valid_r || out_ch.ready);

  always_comb begin
    diff = 13'(q_head.tenths) - 13'(last_good_r);
    mag  = diff[12] ? 12'(-diff) : diff[11:0];
    last_good_nxt = last_good_r;
    have_prev_nxt = have_prev_r;
    tenths_nxt    = tenths_r;
    ok_nxt        = ok_r;
    big_nxt       = big_r;
    valid_nxt     = valid_r;
    if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    if (pop) begin
      valid_nxt = 1'b1;
      ok_nxt    = q_head.ok;
      if (q_head.ok) begin
        tenths_nxt    = q_head.tenths;
        big_nxt       = have_prev_r && (mag > 12'(threshold));
        last_good_nxt = q_head.tenths;
        have_prev_nxt = 1'b1;
      end else begin
        // bad CRC: report the held value
        tenths_nxt = last_good_r;
        big_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      last_good_r <= '0;
      have_prev_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      last_good_r <= last_good_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tenths_r <= tenths_nxt;
    ok_r     <= ok_nxt;
    big_r    <= big_nxt;
  end

  assign out_ch.valid              = valid_r;
  assign out_ch.temperature_tenths = tenths_r;
  assign out_ch.crc_ok             = ok_r;
  assign out_ch.big_change         = big_r;

  a_bad_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !ok_r |-> !big_r)
    else $error("change flagged on bad CRC word");

  a_good_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_head.ok |=> (last_good_r == tenths_r) && have_prev_r)
    else $error("last good value not updated");

  a_first_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !have_prev_r |=> !big_r)
    else $error("change flagged without earlier reading");

endmodule

### src/scratchpad_crc_temperature_check.sv
// A result is queued on the frame's last byte, then moved into the output register.
// Throughput: one byte per cycle; the CRC is done a byte per cycle in the front end,
// so a result comes every FRAME_BYTES bytes. A 2-entry queue and the output register
// let a stalled output hold up to three results before in_ch.ready drops.
// Reset (rst_n low, synchronous): byte count, CRC, queue, output valid, last good
// reading cleared; change_threshold returns to 50.
module scratchpad_crc_temperature_check #(
  parameter int FRAME_BYTES = 9
) (
  input  logic                            clk,
  input  logic                            rst_n,
  scc_in_if.sink                          in_ch,
  scc_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [scc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [scc_pkg::THRESH_W-1:0] thresh_r, thresh_nxt;
  logic              accept, push, pop, full, not_empty;
  scc_pkg::reading_t push_data, head;

  // config register
  assign pready = 1'b1;
  always_comb begin
    thresh_nxt = thresh_r;
    if (psel && penable && pwrite && paddr[2] == scc_pkg::REG_THRESHOLD) begin
      thresh_nxt = pwdata[scc_pkg::THRESH_W-1:0];
    end
    prdata = '0;
    if (paddr[2] == scc_pkg::REG_THRESHOLD) begin
      prdata = {{(32 - scc_pkg::THRESH_W){1'b0}}, thresh_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= scc_pkg::THRESH_RESET;
    end else begin
      thresh_r <= thresh_nxt;
    end
  end

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  scc_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_ch.data_byte),
    .frame_start (in_ch.frame_start),
    .push        (push),
    .push_data   (push_data)
  );

  scc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  scc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (thresh_r),
    .q_valid   (not_empty),
    .q_head    (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

### verif/scc_reading_checker.sv
module scc_reading_checker #(
  parameter int FRAME_BYTES = 9
) (
  input  logic                           clk,
  input  logic                           rst_n,
  scc_in_if                              in_ch,
  scc_out_if                             out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [scc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  input  logic [31:0]                    prdata,
  output int                             failures,
  output int                             waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [scc_pkg::TENTHS_W-1:0] tenths;
    logic                                ok;
    logic                                big;
  } reading_word_t;

  reading_word_t                       readings_q[$];
  logic [scc_pkg::THRESH_W-1:0]        threshold;
  logic [3:0]                          byte_cnt;
  logic [7:0]                          crc_acc;
  logic [7:0]                          temp_lo;
  logic [7:0]                          temp_hi;
  logic signed [scc_pkg::TENTHS_W-1:0] last_good;
  logic                                seen_good;

  always @(posedge clk) begin : track
    logic [7:0]    d;
    logic          fbit;
    logic [11:0]   raw_u;
    int            scaled;
    int            fresh;
    int            delta;
    reading_word_t want;

    if (!rst_n) begin
      failures  = 0;
      threshold = scc_pkg::THRESH_RESET;
      byte_cnt  = '0;
      crc_acc   = '0;
      temp_lo   = '0;
      temp_hi   = '0;
      last_good = '0;
      seen_good = 1'b0;
      readings_q.delete();
    end else begin
      // register index sits in paddr[2]; the other index is unmapped
      if (psel && penable && pready && paddr[2] == scc_pkg::REG_THRESHOLD) begin
        if (pwrite) begin
          threshold = pwdata[scc_pkg::THRESH_W-1:0];
        end else if (prdata[scc_pkg::THRESH_W-1:0] !== threshold) begin
          $error("change_threshold readback: expected %0d, got %0d",
                 threshold, prdata[scc_pkg::THRESH_W-1:0]);
          failures++;
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        d = in_ch.data_byte;
        if (in_ch.frame_start) begin
          byte_cnt = '0;
          crc_acc  = '0;
        end
        // reflected CRC-8, lsb first
        for (int b = 0; b < 8; b++) begin
          fbit    = crc_acc[0] ^ d[b];
          crc_acc = crc_acc >> 1;
          if (fbit) crc_acc = crc_acc ^ scc_pkg::CRC_POLY;
        end
        if (byte_cnt == 4'd0) temp_lo = d;
        else if (byte_cnt == 4'd1) temp_hi = d;
        byte_cnt = byte_cnt + 4'd1;

        if (byte_cnt == 4'(FRAME_BYTES)) begin
          want.ok     = (crc_acc == 8'h00);
          want.big    = 1'b0;
          want.tenths = last_good;
          if (want.ok) begin
            raw_u  = {temp_hi[3:0], temp_lo};
            scaled = $signed(raw_u) * 10;
            fresh  = scaled >>> 4;  // floor toward minus infinity
            delta  = fresh - last_good;
            if (delta < 0) delta = -delta;
            want.big    = seen_good && (delta > int'(threshold));
            last_good   = fresh[scc_pkg::TENTHS_W-1:0];
            seen_good   = 1'b1;
            want.tenths = last_good;
          end
          byte_cnt = '0;
          crc_acc  = '0;
          readings_q.push_back(want);
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        if (readings_q.size() == 0) begin
          $error("result word with nothing pending: temperature_tenths %0d",
                 out_ch.temperature_tenths);
          failures++;
        end else begin
          want = readings_q.pop_front();
          if (out_ch.temperature_tenths !== want.tenths) begin
            $error("temperature_tenths: expected %0d, got %0d",
                   want.tenths, out_ch.temperature_tenths);
            failures++;
          end
          if (out_ch.crc_ok !== want.ok) begin
            $error("crc_ok: expected %0b, got %0b", want.ok, out_ch.crc_ok);
            failures++;
          end
          if (out_ch.big_change !== want.big) begin
            $error("big_change: expected %0b, got %0b", want.big, out_ch.big_change);
            failures++;
          end
        end
      end
    end
    waiting = readings_q.size();
  end

endmodule

### verif/tb_scratchpad_crc_temperature_check.sv
module tb_scratchpad_crc_temperature_check;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [scc_pkg::THRESH_W-1:0] thresh_t;

  localparam int FRAME_BYTES  = 9;
  localparam int RANDOM_BYTES = 1300;
  localparam int TAIL_CYCLES  = 12;
  localparam logic [scc_pkg::CFG_ADDR_W-1:0] THRESH_ADDR = {scc_pkg::REG_THRESHOLD, 2'b00};
  localparam logic [scc_pkg::CFG_ADDR_W-1:0] SPARE_ADDR  = {~scc_pkg::REG_THRESHOLD, 2'b00};

  logic                           clk;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [scc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;
  int                             failures;
  int                             waiting;
  int                             sent;
  bit                             calm;

  scc_in_if  in_ch ();
  scc_out_if out_ch ();

  scratchpad_crc_temperature_check #(.FRAME_BYTES(FRAME_BYTES)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scc_reading_checker #(.FRAME_BYTES(FRAME_BYTES)) chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .failures (failures),
    .waiting  (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_byte(input logic [7:0] d, input logic start);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= d;
    in_ch.frame_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_frame(input logic [11:0] raw, input logic start, input bit corrupt);
    logic [7:0] fbuf [FRAME_BYTES];
    logic [7:0] crc;
    logic       fbit;
    logic [3:0] nib;
    int         at;
    nib     = 4'($urandom_range(0, 15));
    fbuf[0] = raw[7:0];
    fbuf[1] = {nib, raw[11:8]};  // upper nibble is don't-care for the decode
    for (int i = 2; i < FRAME_BYTES - 1; i++) fbuf[i] = 8'($urandom_range(0, 255));
    crc = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      for (int b = 0; b < 8; b++) begin
        fbit = crc[0] ^ fbuf[i][b];
        crc  = crc >> 1;
        if (fbit) crc = crc ^ scc_pkg::CRC_POLY;
      end
    end
    fbuf[FRAME_BYTES-1] = crc;  // residue over the whole frame is then zero
    if (corrupt) begin
      at       = $urandom_range(0, FRAME_BYTES - 1);
      fbuf[at] = fbuf[at] ^ (8'd1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(fbuf[i], (i == 0) ? start : 1'b0);
  endtask

  task automatic apb_xfer(input logic wr, input logic [scc_pkg::CFG_ADDR_W-1:0] a,
                          input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  initial begin : sink_pace
    int hold;
    hold         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0)
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 80) : $urandom_range(1, 4);
      end
    end
  end

  initial begin : stim
    int          phase;
    int          r;
    int          k;
    int          step;
    int          phase_end;
    int          stop_at;
    logic [11:0] raw;
    logic [11:0] prev_raw;
    thresh_t     thr_val;
    logic [31:0] wdata;
    bit          aligned;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.frame_start = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    calm              = 1'b0;
    sent              = 0;
    thr_val           = scc_pkg::THRESH_RESET;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // bad frame before any good one, then the two temperature extremes
    send_frame(12'h800, 1'b1, 1'b1);
    send_frame(12'h7FF, 1'b1, 1'b0);
    send_frame(12'h800, 1'b1, 1'b0);
    prev_raw = 12'h800;
    aligned  = 1'b1;

    stop_at = sent + RANDOM_BYTES;
    phase   = 0;
    while (sent < stop_at) begin
      // all results in before the threshold moves
      drain();
      case (phase)
        0: thr_val = '0;
        1: thr_val = '1;
        2: thr_val = scc_pkg::THRESH_RESET;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 15) thr_val = '0;
          else if (r < 30) thr_val = '1;
          else if (r < 60) thr_val = thresh_t'($urandom_range(0, 120));
          else thr_val = thresh_t'($urandom_range(0, 2047));
        end
      endcase
      wdata                         = $urandom();
      wdata[scc_pkg::THRESH_W-1:0]  = thr_val;
      apb_xfer(1'b1, THRESH_ADDR, wdata);
      apb_xfer(1'b0, THRESH_ADDR, '0);
      if (phase == 2) begin
        apb_xfer(1'b1, SPARE_ADDR, $urandom());
        apb_xfer(1'b0, THRESH_ADDR, '0);
      end
      calm      = ($urandom_range(0, 3) == 0);
      phase_end = sent + $urandom_range(110, 200);

      while (sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 62) begin
          k = $urandom_range(0, 3);
          if (k < 2) begin
            // land right around the threshold in tenths
            step = (int'(thr_val) * 16) / 10 + int'($urandom_range(0, 6)) - 3;
            if (k == 1) step = -step;
            raw = prev_raw + step[11:0];
          end else if (k == 2) begin
            raw = prev_raw + 12'(int'($urandom_range(0, 7)) - 3);
          end else begin
            raw = 12'($urandom_range(0, 4095));
          end
          // a frame that follows a complete one may leave frame_start low
          send_frame(raw, !(aligned && $urandom_range(0, 9) == 0), 1'b0);
          prev_raw = raw;
          aligned  = 1'b1;
        end else if (r < 78) begin
          send_frame(12'($urandom_range(0, 4095)), 1'b1, 1'b1);
          aligned = 1'b1;
        end else if (r < 90) begin
          // frame cut short; the next start restarts the count
          k = $urandom_range(1, FRAME_BYTES - 1);
          for (int i = 0; i < k; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
          aligned = 1'b0;
        end else begin
          k = $urandom_range(1, 12);
          for (int i = 0; i < k; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          aligned = 1'b0;
        end
      end
      phase++;
    end

    drain();
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
